>>> hdl/vbov_pkg.sv
// shared widths, defaults and register indexes for the volume bar aggregator
`timescale 1ns / 1ps

package vbov_pkg;

  // port widths of the trade and result fields
  localparam int PRICE_W  = 32;
  localparam int VOLUME_W = 48;
  localparam int BINS_W   = 49;

  // bin size register and carried volume width
  localparam int BIN_W = 32;

  // defaults for the top level parameters
  localparam int PRICE_BITS_DEF  = 32;
  localparam int VOLUME_BITS_DEF = 48;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_VOLUME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUMULATIVE = 1'b1;

endpackage

>>> hdl/vbov_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module vbov_mul #(
  parameter int AW = vbov_pkg::PRICE_BITS_DEF,
  parameter int BW = vbov_pkg::BIN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] prod,
  output logic             done
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] prod_r;
  logic [AW+BW-1:0] prod_nxt;
  logic [AW:0]      sum;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  // upper half accumulates, lower half holds the multiplier bits still to use
  always_comb begin
    sum      = {1'b0, prod_r[AW+BW-1:BW]} + (prod_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});
    prod_nxt = {sum, prod_r[BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      prod_r <= {{AW{1'b0}}, b};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

>>> hdl/vbov_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module vbov_div #(
  parameter int NW = vbov_pkg::PRICE_BITS_DEF + vbov_pkg::BIN_W,
  parameter int DW = vbov_pkg::BIN_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  // shift the next dividend bit into the partial remainder and try the subtract
  always_comb begin
    trial = {rem_r, quo_r[NW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

>>> hdl/volume_bar_ohlc_vwap_core.sv
// volume-clock bar aggregator: ohlc, vwap and completed bin count per trade
// in the bar a trade runs a multiply, then a divide unless the bar stays empty; one that
// completes it runs multiply, divide, divide, multiply (no first multiply after a lowered
// bin); a falling cumulative total goes straight out; serial multiplier (one bit a cycle)
// and divider (one quotient bit a cycle); one trade at a time, result waits in output reg
// synchronous active-low reset clears bar state, sets bin_volume to 1, cumulative off
`timescale 1ns / 1ps

module volume_bar_ohlc_vwap_core #(
  parameter int PRICE_BITS  = vbov_pkg::PRICE_BITS_DEF,
  parameter int VOLUME_BITS = vbov_pkg::VOLUME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [vbov_pkg::PRICE_W-1:0]    in_price,
  input  logic [vbov_pkg::VOLUME_W-1:0]   in_volume,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vbov_pkg::PRICE_W-1:0]    out_bar_open,
  output logic [vbov_pkg::PRICE_W-1:0]    out_bar_high,
  output logic [vbov_pkg::PRICE_W-1:0]    out_bar_low,
  output logic [vbov_pkg::PRICE_W-1:0]    out_bar_close,
  output logic [vbov_pkg::PRICE_W-1:0]    out_vwap,
  output logic                            out_vwap_valid,
  output logic [vbov_pkg::BINS_W-1:0]     out_bins_done,
  output logic                            out_volume_error,

  input  logic                            cfg_we,
  input  logic [vbov_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbov_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PW     = vbov_pkg::PRICE_W;
  localparam int BW     = vbov_pkg::BIN_W;
  localparam int NB     = vbov_pkg::BINS_W;
  localparam int TOT_W  = ((VOLUME_BITS > BW) ? VOLUME_BITS : BW) + 1;
  localparam int TW     = PRICE_BITS + BW;
  localparam int DIV_NW = (TW > TOT_W) ? TW : TOT_W;

  localparam logic [DIV_NW-1:0] VW_MAX = {{(DIV_NW - PRICE_BITS){1'b0}}, {PRICE_BITS{1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL1,
    S_DIV1,
    S_DIV2,
    S_MUL2,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [BW-1:0]          bin_r;
  logic                   cum_r;
  logic [BW-1:0]          bin_eff;

  // bar state
  logic                   started_r;
  logic [PRICE_BITS-1:0]  open_r;
  logic [PRICE_BITS-1:0]  high_r;
  logic [PRICE_BITS-1:0]  low_r;
  logic [BW-1:0]          carried_r;
  logic [TW-1:0]          turnover_r;
  logic [VOLUME_BITS-1:0] last_total_r;

  // current trade
  logic [PRICE_BITS-1:0]  price_r;
  logic [VOLUME_BITS-1:0] vol_r;
  logic [TOT_W-1:0]       total_r;
  logic                   partial_r;

  // result being built
  logic [PW-1:0]          res_open_r;
  logic [PW-1:0]          res_high_r;
  logic [PW-1:0]          res_low_r;
  logic [PW-1:0]          res_close_r;
  logic [PW-1:0]          res_vwap_r;
  logic                   res_valid_r;
  logic [NB-1:0]          res_bins_r;
  logic                   res_err_r;

  // output register
  logic                   out_valid_r;
  logic [PW-1:0]          out_open_r;
  logic [PW-1:0]          out_high_r;
  logic [PW-1:0]          out_low_r;
  logic [PW-1:0]          out_close_r;
  logic [PW-1:0]          out_vwap_r;
  logic                   out_vwap_valid_r;
  logic [NB-1:0]          out_bins_r;
  logic                   out_err_r;

  // serial units
  logic                   mul_start_r;
  logic [BW-1:0]          mul_b_r;
  logic [TW-1:0]          mul_prod;
  logic                   mul_done;
  logic                   div_start_r;
  logic [DIV_NW-1:0]      div_n_r;
  logic [BW-1:0]          div_d_r;
  logic [DIV_NW-1:0]      div_q;
  logic [BW-1:0]          div_rem;
  logic                   div_done;

  // trade decode
  logic                   vol_err;
  logic [VOLUME_BITS-1:0] vol_eff;
  logic [TOT_W-1:0]       total;
  logic                   partial;
  logic [PRICE_BITS-1:0]  o_new;
  logic [PRICE_BITS-1:0]  h_new;
  logic [PRICE_BITS-1:0]  l_new;
  logic [TW-1:0]          turn_sum;
  logic                   out_free;

  always_comb begin
    bin_eff  = (bin_r == '0) ? BW'(1) : bin_r;
    vol_err  = cum_r && (vol_r < last_total_r);
    vol_eff  = cum_r ? (vol_r - last_total_r) : vol_r;
    total    = TOT_W'(carried_r) + TOT_W'(vol_eff);
    partial  = (total < TOT_W'(bin_eff));
    o_new    = started_r ? open_r : price_r;
    h_new    = (!started_r || price_r > high_r) ? price_r : high_r;
    l_new    = (!started_r || price_r < low_r) ? price_r : low_r;
    turn_sum = turnover_r + mul_prod;
    out_free = !out_valid_r || out_ready;
  end

  vbov_mul #(
    .AW (PRICE_BITS),
    .BW (BW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (price_r),
    .b     (mul_b_r),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  vbov_div #(
    .NW (DIV_NW),
    .DW (BW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_n_r),
    .den   (div_d_r),
    .quo   (div_q),
    .rem   (div_rem),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= BW'(1);
      cum_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vbov_pkg::CFG_BIN_VOLUME: bin_r <= cfg_data[BW-1:0];
        vbov_pkg::CFG_CUMULATIVE: cum_r <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      started_r    <= 1'b0;
      open_r       <= '0;
      high_r       <= '0;
      low_r        <= '0;
      carried_r    <= '0;
      turnover_r   <= '0;
      last_total_r <= '0;
      out_valid_r  <= 1'b0;
      mul_start_r  <= 1'b0;
      div_start_r  <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            price_r <= in_price[PRICE_BITS-1:0];
            vol_r   <= in_volume[VOLUME_BITS-1:0];
            state_r <= S_PREP;
          end
        end

        S_PREP: begin
          res_bins_r <= '0;
          if (vol_err) begin
            // decreasing running total: error result, bar state untouched
            res_open_r  <= '0;
            res_high_r  <= '0;
            res_low_r   <= '0;
            res_close_r <= '0;
            res_vwap_r  <= '0;
            res_valid_r <= 1'b0;
            res_err_r   <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            res_err_r   <= 1'b0;
            res_open_r  <= PW'(o_new);
            res_high_r  <= PW'(h_new);
            res_low_r   <= PW'(l_new);
            res_close_r <= PW'(price_r);
            started_r   <= 1'b1;
            open_r      <= o_new;
            high_r      <= h_new;
            low_r       <= l_new;
            if (cum_r) begin
              last_total_r <= vol_r;
            end
            total_r   <= total;
            partial_r <= partial;
            if (partial) begin
              carried_r   <= BW'(total);
              mul_b_r     <= BW'(vol_eff);
              mul_start_r <= 1'b1;
              state_r     <= S_MUL1;
            end else if (carried_r < bin_eff) begin
              // top the bar up to exactly one bin at this price
              mul_b_r     <= bin_eff - carried_r;
              mul_start_r <= 1'b1;
              state_r     <= S_MUL1;
            end else begin
              // bin lowered to or below carried volume: no top-up
              div_n_r     <= DIV_NW'(turnover_r);
              div_d_r     <= bin_eff;
              div_start_r <= 1'b1;
              state_r     <= S_DIV1;
            end
          end
        end

        S_MUL1: begin
          if (mul_done) begin
            turnover_r <= turn_sum;
            if (partial_r && carried_r == '0) begin
              res_vwap_r  <= '0;
              res_valid_r <= 1'b0;
              state_r     <= S_OUT;
            end else begin
              div_n_r     <= DIV_NW'(turn_sum);
              div_d_r     <= partial_r ? carried_r : bin_eff;
              div_start_r <= 1'b1;
              state_r     <= S_DIV1;
            end
          end
        end

        S_DIV1: begin
          if (div_done) begin
            res_valid_r <= 1'b1;
            if (partial_r) begin
              res_vwap_r <= PW'(div_q);
              state_r    <= S_OUT;
            end else begin
              res_vwap_r  <= (div_q > VW_MAX) ? PW'(VW_MAX) : PW'(div_q);
              div_n_r     <= DIV_NW'(total_r);
              div_d_r     <= bin_eff;
              div_start_r <= 1'b1;
              state_r     <= S_DIV2;
            end
          end
        end

        S_DIV2: begin
          if (div_done) begin
            // quotient is the bin count, remainder opens the next bar
            res_bins_r  <= NB'(div_q);
            carried_r   <= div_rem;
            open_r      <= price_r;
            high_r      <= price_r;
            low_r       <= price_r;
            mul_b_r     <= div_rem;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL2;
          end
        end

        S_MUL2: begin
          if (mul_done) begin
            turnover_r <= mul_prod;
            state_r    <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_open_r       <= res_open_r;
            out_high_r       <= res_high_r;
            out_low_r        <= res_low_r;
            out_close_r      <= res_close_r;
            out_vwap_r       <= res_vwap_r;
            out_vwap_valid_r <= res_valid_r;
            out_bins_r       <= res_bins_r;
            out_err_r        <= res_err_r;
            state_r          <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_bar_open     = out_open_r;
  assign out_bar_high     = out_high_r;
  assign out_bar_low      = out_low_r;
  assign out_bar_close    = out_close_r;
  assign out_vwap         = out_vwap_r;
  assign out_vwap_valid   = out_vwap_valid_r;
  assign out_bins_done    = out_bins_r;
  assign out_volume_error = out_err_r;

endmodule

>>> tb/tb.sv
// testbench for the volume bar aggregator: predicted ohlc, vwap and bin count per trade
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_TRADES  = 150;
  localparam logic [vbov_pkg::VOLUME_W-1:0] VOLUME_MAX = '1;
  localparam logic [vbov_pkg::PRICE_W-1:0]  PRICE_MAX  = '1;

  typedef struct packed {
    logic [vbov_pkg::PRICE_W-1:0] bar_open;
    logic [vbov_pkg::PRICE_W-1:0] bar_high;
    logic [vbov_pkg::PRICE_W-1:0] bar_low;
    logic [vbov_pkg::PRICE_W-1:0] bar_close;
    logic [vbov_pkg::PRICE_W-1:0] vwap;
    logic                         vwap_valid;
    logic [vbov_pkg::BINS_W-1:0]  bins_done;
    logic                         volume_error;
  } bar_result_t;

  class bar_tracker;
    bar_result_t                expected_bars[$];
    int                         mismatches = 0;
    logic [vbov_pkg::BIN_W-1:0] bin_size   = 1;
    bit                         cumulative = 0;
    bit                         started    = 0;
    logic [63:0]                open_p     = 0;
    logic [63:0]                high_p     = 0;
    logic [63:0]                low_p      = 0;
    logic [63:0]                carried    = 0;
    logic [63:0]                turnover   = 0;
    logic [63:0]                last_total = 0;

    function void set_register(logic [vbov_pkg::CFG_IDX_W-1:0] idx,
                               logic [vbov_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        vbov_pkg::CFG_BIN_VOLUME: bin_size = data[vbov_pkg::BIN_W-1:0];
        vbov_pkg::CFG_CUMULATIVE: cumulative = data[0];
        default: ;
      endcase
    endfunction

    function void take_trade(logic [vbov_pkg::PRICE_W-1:0] price,
                             logic [vbov_pkg::VOLUME_W-1:0] volume);
      bar_result_t r;
      logic [63:0] p, vol, bin_eff, total, vw, nbin;
      r       = '0;
      p       = 64'(price);
      vol     = 64'(volume);
      bin_eff = (bin_size == 0) ? 64'd1 : 64'(bin_size);
      if (cumulative) begin
        // a falling running total is flagged and leaves the bar untouched
        if (vol < last_total) begin
          r.volume_error = 1'b1;
          expected_bars.push_back(r);
          return;
        end
        vol        = vol - last_total;
        last_total = 64'(volume);
      end
      if (!started) begin
        open_p  = p;
        high_p  = p;
        low_p   = p;
        started = 1'b1;
      end
      if (p > high_p) high_p = p;
      if (p < low_p) low_p = p;
      r.bar_open  = open_p[vbov_pkg::PRICE_W-1:0];
      r.bar_high  = high_p[vbov_pkg::PRICE_W-1:0];
      r.bar_low   = low_p[vbov_pkg::PRICE_W-1:0];
      r.bar_close = price;
      total = carried + vol;
      if (total < bin_eff) begin
        carried  = total;
        turnover = turnover + vol * p;
        if (carried != 0) begin
          vw           = turnover / carried;
          r.vwap       = vw[vbov_pkg::PRICE_W-1:0];
          r.vwap_valid = 1'b1;
        end
      end else begin
        // top up to exactly one bin, unless a lowered bin already sits below the carry
        if (carried < bin_eff) turnover = turnover + (bin_eff - carried) * p;
        vw = turnover / bin_eff;
        if (vw > 64'(PRICE_MAX)) vw = 64'(PRICE_MAX);
        r.vwap       = vw[vbov_pkg::PRICE_W-1:0];
        r.vwap_valid = 1'b1;
        nbin         = total / bin_eff;
        r.bins_done  = nbin[vbov_pkg::BINS_W-1:0];
        carried      = total % bin_eff;
        open_p       = p;
        high_p       = p;
        low_p        = p;
        turnover     = carried * p;
      end
      expected_bars.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_bar(bar_result_t got);
      bar_result_t want;
      if (expected_bars.size() == 0) begin
        $error("result transfer with no trade outstanding");
        mismatches++;
        return;
      end
      want = expected_bars.pop_front();
      compare("bar_open", 64'(want.bar_open), 64'(got.bar_open));
      compare("bar_high", 64'(want.bar_high), 64'(got.bar_high));
      compare("bar_low", 64'(want.bar_low), 64'(got.bar_low));
      compare("bar_close", 64'(want.bar_close), 64'(got.bar_close));
      compare("vwap", 64'(want.vwap), 64'(got.vwap));
      compare("vwap_valid", 64'(want.vwap_valid), 64'(got.vwap_valid));
      compare("bins_done", 64'(want.bins_done), 64'(got.bins_done));
      compare("volume_error", 64'(want.volume_error), 64'(got.volume_error));
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [vbov_pkg::PRICE_W-1:0]    in_price;
  logic [vbov_pkg::VOLUME_W-1:0]   in_volume;
  logic                            out_valid;
  logic                            out_ready;
  logic [vbov_pkg::PRICE_W-1:0]    out_bar_open;
  logic [vbov_pkg::PRICE_W-1:0]    out_bar_high;
  logic [vbov_pkg::PRICE_W-1:0]    out_bar_low;
  logic [vbov_pkg::PRICE_W-1:0]    out_bar_close;
  logic [vbov_pkg::PRICE_W-1:0]    out_vwap;
  logic                            out_vwap_valid;
  logic [vbov_pkg::BINS_W-1:0]     out_bins_done;
  logic                            out_volume_error;
  logic                            cfg_we;
  logic [vbov_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vbov_pkg::CFG_DATA_W-1:0] cfg_data;

  bar_tracker  bars = new;
  bit          calm = 0;
  bit          cum_mode = 0;
  logic [63:0] cur_bin = 1;
  logic [63:0] run_total = 0;
  int          idle_cycles = 0;

  volume_bar_ohlc_vwap_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_price         (in_price),
    .in_volume        (in_volume),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bar_open     (out_bar_open),
    .out_bar_high     (out_bar_high),
    .out_bar_low      (out_bar_low),
    .out_bar_close    (out_bar_close),
    .out_vwap         (out_vwap),
    .out_vwap_valid   (out_vwap_valid),
    .out_bins_done    (out_bins_done),
    .out_volume_error (out_volume_error),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(input logic [vbov_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vbov_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    bars.set_register(idx, data);
  endtask

  task automatic apply_setting(input logic [vbov_pkg::BIN_W-1:0] bin_size, input bit cum);
    write_reg(vbov_pkg::CFG_BIN_VOLUME, vbov_pkg::CFG_DATA_W'(bin_size));
    write_reg(vbov_pkg::CFG_CUMULATIVE, vbov_pkg::CFG_DATA_W'(cum));
    cfg_we   <= 1'b0;
    cur_bin  = (bin_size == 0) ? 64'd1 : 64'(bin_size);
    cum_mode = cum;
  endtask

  task automatic send_trade(input logic [vbov_pkg::PRICE_W-1:0] price,
                            input logic [vbov_pkg::VOLUME_W-1:0] volume);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_price  <= price;
    in_volume <= volume;
    do @(posedge clk); while (in_ready !== 1'b1);
    bars.take_trade(price, volume);
    if (cum_mode && 64'(volume) >= run_total) run_total = 64'(volume);
  endtask

  // hold off new trades until every outstanding bar has come back
  task automatic settle_bars();
    in_valid <= 1'b0;
    do @(posedge clk); while (bars.expected_bars.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [vbov_pkg::PRICE_W-1:0] pick_price();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PRICE_MAX;
      default: return vbov_pkg::PRICE_W'($urandom);
    endcase
  endfunction

  function automatic logic [vbov_pkg::VOLUME_W-1:0] pick_volume();
    logic [63:0] r, v;
    int sel;
    r   = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (!cum_mode) begin
      case (sel)
        0: v = 0;
        1: v = r;
        2: v = cur_bin * $urandom_range(1, 3);
        default: v = r % (2 * cur_bin + 1);
      endcase
    end else begin
      if (sel == 0) v = run_total;
      else if (sel == 1 && run_total != 0) v = r % run_total;
      else begin
        v = run_total + r % (2 * cur_bin + 1);
        if (v > 64'(VOLUME_MAX)) v = 64'(VOLUME_MAX);
      end
    end
    return v[vbov_pkg::VOLUME_W-1:0];
  endfunction

  // result side: random stall once a result is waiting, then take it
  initial begin
    int stall;
    bar_result_t got;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (out_valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.bar_open     = out_bar_open;
      got.bar_high     = out_bar_high;
      got.bar_low      = out_bar_low;
      got.bar_close    = out_bar_close;
      got.vwap         = out_vwap;
      got.vwap_valid   = out_vwap_valid;
      got.bins_done    = out_bins_done;
      got.volume_error = out_volume_error;
      bars.check_bar(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [vbov_pkg::BIN_W-1:0] bin_pick;
    in_valid  <= 1'b0;
    in_price  <= '0;
    in_volume <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= vbov_pkg::CFG_BIN_VOLUME;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bin of zero acts as one; first trade with no volume has no vwap
    apply_setting('0, 1'b0);
    send_trade(100, 0);
    send_trade(PRICE_MAX, VOLUME_MAX);
    send_trade(0, 1);
    send_trade(0, 0);
    settle_bars();

    // partial bars, then one trade closing several bins with a carry
    apply_setting(1000, 1'b0);
    send_trade(500, 300);
    send_trade(700, 200);
    send_trade(300, 100);
    send_trade(400, 2500);
    send_trade(PRICE_MAX, 899);
    send_trade(1, 1);
    send_trade(32'hF000_0000, 900);
    settle_bars();

    // bin lowered below the carry: no top-up, vwap saturates
    apply_setting(100, 1'b0);
    send_trade(32'hF000_0000, 5);
    send_trade(2, 95);
    settle_bars();

    // running totals: rise, repeat, fall, jump
    apply_setting(32'hFFFF_FFFF, 1'b1);
    send_trade(1000, run_total[vbov_pkg::VOLUME_W-1:0] + 500);
    send_trade(1001, run_total[vbov_pkg::VOLUME_W-1:0]);
    send_trade(999, run_total[vbov_pkg::VOLUME_W-1:0] - 1);
    send_trade(1002, run_total[vbov_pkg::VOLUME_W-1:0] + 48'd10_000_000_000);
    settle_bars();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: bin_pick = '0;
        1: bin_pick = vbov_pkg::BIN_W'($urandom_range(1, 16));
        2: bin_pick = vbov_pkg::BIN_W'($urandom_range(1, 5000));
        3: bin_pick = vbov_pkg::BIN_W'($urandom);
        4: bin_pick = '1;
        default: bin_pick = vbov_pkg::BIN_W'($urandom_range(1, 1_000_000));
      endcase
      apply_setting(bin_pick, bit'($urandom_range(0, 1)));
      repeat (PHASE_TRADES) send_trade(pick_price(), pick_volume());
      settle_bars();
    end

    // running total pushed to the top of its range
    calm = 1'b0;
    apply_setting(1, 1'b1);
    send_trade(7, VOLUME_MAX);
    send_trade(8, VOLUME_MAX - 1);
    send_trade(9, VOLUME_MAX);
    settle_bars();

    repeat (250) @(posedge clk);
    if (bars.mismatches == 0 && bars.expected_bars.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
